@@ hdl/ulecm_pkg.sv @@
// Shared types, character codes and the microcode program for the line editor.
// Used by the sequencer, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ulecm_pkg;

   // Request modes.
   localparam logic [1:0] MODE_RX    = 2'd0;
   localparam logic [1:0] MODE_PARSE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_LOAD  = 2'd3;

   // Terminal characters.
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SP = 8'h20;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
      logic [2:0] cmd_slot;
      logic [2:0] cmd_pos;
   } req_item_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       status;
      logic       line_end;
      logic       match_found;
      logic [2:0] command_number;
      logic       last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLR,
      OP_BACK,
      OP_STORE,
      OP_CLEAR,
      OP_LOAD,
      OP_PINIT,
      OP_READ,
      OP_ADV,
      OP_NEXT,
      OP_HIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_DISPATCH,
      C_CLR_MORE,
      C_KFULL,
      C_TZERO,
      C_NEQ,
      C_CMD_LAST
   } cond_type;

   typedef enum logic [2:0] {
      E_NONE,
      E_BS,
      E_SP,
      E_CR,
      E_LF,
      E_DATA
   } echo_sel_type;

   typedef enum logic [2:0] {
      CL_FULL,
      CL_BS,
      CL_CR,
      CL_CHAR,
      CL_PARSE,
      CL_CLEAR,
      CL_LOAD
   } class_type;

   localparam int UPC_W = 5;

   // Microcode entry points.
   localparam logic [UPC_W-1:0] U_CLR   = 5'd0;
   localparam logic [UPC_W-1:0] U_IDLE  = 5'd1;
   localparam logic [UPC_W-1:0] U_FULL  = 5'd2;
   localparam logic [UPC_W-1:0] U_BS    = 5'd3;
   localparam logic [UPC_W-1:0] U_BS_SP = 5'd4;
   localparam logic [UPC_W-1:0] U_BS_BS = 5'd5;
   localparam logic [UPC_W-1:0] U_CR    = 5'd6;
   localparam logic [UPC_W-1:0] U_CR_LF = 5'd7;
   localparam logic [UPC_W-1:0] U_CHAR  = 5'd8;
   localparam logic [UPC_W-1:0] U_CLEAR = 5'd9;
   localparam logic [UPC_W-1:0] U_LOAD  = 5'd10;
   localparam logic [UPC_W-1:0] U_PARSE = 5'd11;
   localparam logic [UPC_W-1:0] U_PCHK  = 5'd12;
   localparam logic [UPC_W-1:0] U_PREAD = 5'd13;
   localparam logic [UPC_W-1:0] U_PCMP  = 5'd14;
   localparam logic [UPC_W-1:0] U_PNEQ  = 5'd15;
   localparam logic [UPC_W-1:0] U_PADV  = 5'd16;
   localparam logic [UPC_W-1:0] U_PMISS = 5'd17;
   localparam logic [UPC_W-1:0] U_PLOOP = 5'd18;
   localparam logic [UPC_W-1:0] U_PHIT  = 5'd19;
   localparam logic [UPC_W-1:0] U_PNONE = 5'd20;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
      logic             take;
      logic             emit;
      echo_sel_type     echo;
      logic             status;
      logic             line_end;
      logic             match_hit;
      logic             last;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type word;
      logic          exec;
   } ctl_bus_type;

   typedef struct packed {
      logic      accept;
      class_type cls;
      logic      clr_more;
      logic      kfull;
      logic      tzero;
      logic      neq;
      logic      cmd_last;
      logic      out_free;
   } flag_bus_type;

   // The program. A step whose condition holds jumps to its target, otherwise
   // it falls through; the dispatch step jumps to the entry for the request's class.
   function automatic ctrl_word_type ucode_rom(input logic [UPC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: C_NEXT, target: U_IDLE, take: 1'b0, emit: 1'b0,
            echo: E_NONE, status: 1'b0, line_end: 1'b0, match_hit: 1'b0,
            last: 1'b0};
      unique case (pc)
         U_CLR: begin
            w.op = OP_CLR; w.cond = C_CLR_MORE; w.target = U_CLR;
         end
         U_IDLE: begin
            w.take = 1'b1; w.cond = C_DISPATCH;
         end
         U_FULL: begin
            w.emit = 1'b1; w.status = 1'b1; w.last = 1'b1; w.cond = C_ALWAYS;
         end
         U_BS: begin
            w.op = OP_BACK; w.emit = 1'b1; w.echo = E_BS;
         end
         U_BS_SP: begin
            w.emit = 1'b1; w.echo = E_SP;
         end
         U_BS_BS: begin
            w.emit = 1'b1; w.echo = E_BS; w.last = 1'b1; w.cond = C_ALWAYS;
         end
         U_CR: begin
            w.op = OP_STORE; w.emit = 1'b1; w.echo = E_CR; w.line_end = 1'b1;
         end
         U_CR_LF: begin
            w.emit = 1'b1; w.echo = E_LF; w.line_end = 1'b1; w.last = 1'b1;
            w.cond = C_ALWAYS;
         end
         U_CHAR: begin
            w.op = OP_STORE; w.emit = 1'b1; w.echo = E_DATA; w.last = 1'b1;
            w.cond = C_ALWAYS;
         end
         U_CLEAR: begin
            w.op = OP_CLEAR; w.emit = 1'b1; w.last = 1'b1; w.cond = C_ALWAYS;
         end
         U_LOAD: begin
            w.op = OP_LOAD; w.emit = 1'b1; w.last = 1'b1; w.cond = C_ALWAYS;
         end
         U_PARSE: begin
            w.op = OP_PINIT;
         end
         U_PCHK: begin
            w.cond = C_KFULL; w.target = U_PHIT;
         end
         U_PREAD: begin
            w.op = OP_READ;
         end
         U_PCMP: begin
            w.cond = C_TZERO; w.target = U_PHIT;
         end
         U_PNEQ: begin
            w.cond = C_NEQ; w.target = U_PMISS;
         end
         U_PADV: begin
            w.op = OP_ADV; w.cond = C_ALWAYS; w.target = U_PCHK;
         end
         U_PMISS: begin
            w.op = OP_NEXT; w.cond = C_CMD_LAST; w.target = U_PNONE;
         end
         U_PLOOP: begin
            w.cond = C_ALWAYS; w.target = U_PCHK;
         end
         U_PHIT: begin
            w.op = OP_HIT; w.emit = 1'b1; w.match_hit = 1'b1; w.last = 1'b1;
            w.cond = C_ALWAYS;
         end
         U_PNONE: begin
            w.emit = 1'b1; w.last = 1'b1; w.cond = C_ALWAYS;
         end
         default: begin
            w.cond = C_ALWAYS;
         end
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch_entry(input class_type cls);
      logic [UPC_W-1:0] entry;
      unique case (cls)
         CL_FULL:  entry = U_FULL;
         CL_BS:    entry = U_BS;
         CL_CR:    entry = U_CR;
         CL_CHAR:  entry = U_CHAR;
         CL_PARSE: entry = U_PARSE;
         CL_CLEAR: entry = U_CLEAR;
         CL_LOAD:  entry = U_LOAD;
         default:  entry = U_IDLE;
      endcase
      return entry;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ulecm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ulecm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/ulecm_seq.sv @@
// Microcode sequencer: step counter, program lookup and jump logic.
// Depends on ulecm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ulecm_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ulecm_pkg::flag_bus_type flags,
   output ulecm_pkg::ctl_bus_type  ctl
);
   import ulecm_pkg::*;

   logic [UPC_W-1:0] pc_ff;
   logic [UPC_W-1:0] pc_in;
   ctrl_word_type    word;
   logic             exec;
   logic             cond_hit;

   always_comb begin
      word = ucode_rom(pc_ff);
      // A step that emits waits in place until the output register is free.
      exec = !(word.emit && !flags.out_free);

      unique case (word.cond)
         C_NEXT:     cond_hit = 1'b0;
         C_ALWAYS:   cond_hit = 1'b1;
         C_DISPATCH: cond_hit = 1'b0;
         C_CLR_MORE: cond_hit = flags.clr_more;
         C_KFULL:    cond_hit = flags.kfull;
         C_TZERO:    cond_hit = flags.tzero;
         C_NEQ:      cond_hit = flags.neq;
         C_CMD_LAST: cond_hit = flags.cmd_last;
         default:    cond_hit = 1'b0;
      endcase

      priority if (!exec) begin
         pc_in = pc_ff;
      end else if (word.cond == C_DISPATCH) begin
         pc_in = flags.accept ? dispatch_entry(flags.cls) : pc_ff;
      end else if (cond_hit) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + UPC_W'(1);
      end

      ctl = '{word: word, exec: exec};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= U_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ulecm_dp.sv @@
// Datapath: line ring and command table memories, indexes, fill count,
// parse registers and the result output register.
// Depends on ulecm_pkg and ulecm_ram.
`timescale 1ns / 1ps
`default_nettype none

module ulecm_dp #(
   parameter int RING_DEPTH      = 64,
   parameter int NUM_COMMANDS    = 8,
   parameter int COMMAND_MAX_LEN = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  ulecm_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ulecm_pkg::rsp_item_type rsp_item,
   input  ulecm_pkg::ctl_bus_type  ctl,
   output ulecm_pkg::flag_bus_type flags
);
   import ulecm_pkg::*;

   localparam int RAW  = $clog2(RING_DEPTH);
   localparam int FW   = $clog2(RING_DEPTH + 1);
   localparam int TD   = NUM_COMMANDS * COMMAND_MAX_LEN;
   localparam int TAW  = (TD > 1) ? $clog2(TD) : 1;
   localparam int CW   = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;
   localparam int KW   = $clog2(COMMAND_MAX_LEN + 1);
   localparam int MAXD = (RING_DEPTH > TD) ? RING_DEPTH : TD;
   localparam int CLRW = $clog2(MAXD);

   logic [RAW-1:0]  wr_ff, wr_in;
   logic [RAW-1:0]  rd_ff, rd_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [CLRW-1:0] clr_ff, clr_in;
   logic [RAW-1:0]  p_ff, p_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [TAW-1:0]  base_ff, base_in;
   logic [CW-1:0]   cmd_ff, cmd_in;
   req_item_type    req_ff, req_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_ff, rsp_in;

   logic            ring_we, ring_re;
   logic [RAW-1:0]  ring_waddr;
   logic [7:0]      ring_wdata, ring_rdata;
   logic            tab_we, tab_re;
   logic [TAW-1:0]  tab_waddr, tab_raddr;
   logic [7:0]      tab_wdata, tab_rdata;
   logic            load_ok;
   logic [TAW-1:0]  load_addr;
   logic [7:0]      echo_byte;

   function automatic logic [RAW-1:0] ring_inc(input logic [RAW-1:0] v);
      return (int'(v) == RING_DEPTH - 1) ? '0 : v + RAW'(1);
   endfunction

   ulecm_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (p_ff),
      .rd_data (ring_rdata)
   );

   ulecm_ram #(.WIDTH(8), .DEPTH(TD)) u_table (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (tab_re),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   always_comb begin
      load_ok   = (int'(req_ff.cmd_slot) < NUM_COMMANDS) &&
                  (int'(req_ff.cmd_pos) < COMMAND_MAX_LEN);
      load_addr = TAW'(int'(req_ff.cmd_slot) * COMMAND_MAX_LEN + int'(req_ff.cmd_pos));

      flags.accept   = req_valid && ctl.word.take;
      flags.clr_more = clr_ff != CLRW'(MAXD - 1);
      flags.kfull    = int'(k_ff) == COMMAND_MAX_LEN;
      flags.tzero    = tab_rdata == 8'd0;
      flags.neq      = tab_rdata != ring_rdata;
      flags.cmd_last = cmd_ff == CW'(NUM_COMMANDS - 1);
      flags.out_free = !rsp_valid_ff || rsp_ready;
      priority if (req_item.mode == MODE_PARSE) begin
         flags.cls = CL_PARSE;
      end else if (req_item.mode == MODE_CLEAR) begin
         flags.cls = CL_CLEAR;
      end else if (req_item.mode == MODE_LOAD) begin
         flags.cls = CL_LOAD;
      end else if (int'(fill_ff) >= RING_DEPTH) begin
         flags.cls = CL_FULL;
      end else if (req_item.data_byte == CH_BS) begin
         flags.cls = CL_BS;
      end else if (req_item.data_byte == CH_CR) begin
         flags.cls = CL_CR;
      end else begin
         flags.cls = CL_CHAR;
      end
   end

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      clr_in  = clr_ff;
      p_in    = p_ff;
      k_in    = k_ff;
      base_in = base_ff;
      cmd_in  = cmd_ff;
      req_in  = flags.accept ? req_item : req_ff;

      ring_we    = 1'b0;
      ring_waddr = wr_ff;
      ring_wdata = req_ff.data_byte;
      tab_we     = 1'b0;
      tab_waddr  = load_addr;
      tab_wdata  = req_ff.data_byte;
      ring_re    = ctl.exec && (ctl.word.op == OP_READ);
      tab_re     = ring_re;
      tab_raddr  = base_ff + TAW'(k_ff);

      if (ctl.exec) begin
         unique case (ctl.word.op)
            OP_NOP: begin
            end
            OP_CLR: begin
               ring_waddr = clr_ff[RAW-1:0];
               ring_wdata = 8'd0;
               ring_we    = int'(clr_ff) < RING_DEPTH;
               tab_waddr  = clr_ff[TAW-1:0];
               tab_wdata  = 8'd0;
               tab_we     = int'(clr_ff) < TD;
               clr_in     = clr_ff + CLRW'(1);
            end
            OP_BACK: begin
               if (fill_ff != '0) begin
                  fill_in = fill_ff - FW'(1);
                  wr_in   = (wr_ff == '0) ? RAW'(RING_DEPTH - 1) : wr_ff - RAW'(1);
               end
            end
            OP_STORE: begin
               ring_we = 1'b1;
               wr_in   = ring_inc(wr_ff);
               fill_in = fill_ff + FW'(1);
            end
            OP_CLEAR: begin
               fill_in = '0;
               rd_in   = wr_ff;
            end
            OP_LOAD: begin
               tab_we = load_ok;
            end
            OP_PINIT: begin
               cmd_in  = '0;
               base_in = '0;
               k_in    = '0;
               p_in    = rd_ff;
            end
            OP_READ: begin
            end
            OP_ADV: begin
               k_in = k_ff + KW'(1);
               p_in = ring_inc(p_ff);
            end
            OP_NEXT: begin
               cmd_in  = cmd_ff + CW'(1);
               base_in = base_ff + TAW'(COMMAND_MAX_LEN);
               k_in    = '0;
               p_in    = rd_ff;
            end
            OP_HIT: begin
               rd_in = p_ff;
               // The count saturates at zero when the command is longer.
               if (int'(fill_ff) > int'(k_ff)) begin
                  fill_in = fill_ff - FW'(k_ff);
               end else begin
                  fill_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (ctl.word.echo)
         E_NONE:  echo_byte = 8'd0;
         E_BS:    echo_byte = CH_BS;
         E_SP:    echo_byte = CH_SP;
         E_CR:    echo_byte = CH_CR;
         E_LF:    echo_byte = CH_LF;
         E_DATA:  echo_byte = req_ff.data_byte;
         default: echo_byte = 8'd0;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (ctl.exec && ctl.word.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.echo_valid     = ctl.word.echo != E_NONE;
         rsp_in.echo_byte      = echo_byte;
         rsp_in.status         = ctl.word.status;
         rsp_in.line_end       = ctl.word.line_end;
         rsp_in.match_found    = ctl.word.match_hit;
         rsp_in.command_number = ctl.word.match_hit ? 3'(cmd_ff) : 3'd0;
         rsp_in.last           = ctl.word.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         fill_ff      <= fill_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      k_ff    <= k_in;
      base_ff <= base_in;
      cmd_ff  <= cmd_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/uart_line_editor_command_matcher_core.sv @@
// Line editor with command matcher, run by a microcoded sequencer.
// The result word of a byte, clear or load is registered in the output register by the
// step that the request dispatches to, once that register is free. A new request is taken
// only after the last word of the previous one; a printable byte, clear or load emits one
// word, CR emits CR and LF, backspace emits BS, space and BS; a parse runs the
// one-character-per-pass compare loop over the registered memory reads.
// After reset, req_ready stays low while both memories are swept to zero.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_editor_command_matcher_core #(
   parameter int RING_DEPTH      = 64,
   parameter int NUM_COMMANDS    = 8,
   parameter int COMMAND_MAX_LEN = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ulecm_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ulecm_pkg::rsp_item_type rsp_item
);
   import ulecm_pkg::*;

   ctl_bus_type  ctl;
   flag_bus_type flags;

   ulecm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   ulecm_dp #(
      .RING_DEPTH      (RING_DEPTH),
      .NUM_COMMANDS    (NUM_COMMANDS),
      .COMMAND_MAX_LEN (COMMAND_MAX_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .ctl       (ctl),
      .flags     (flags)
   );

   assign req_ready = ctl.word.take;

endmodule

`default_nettype wire

@@ hdl/ulecm_chk.sv @@
// Port-level checker for the line editor core, with its bind statement.
// Depends on ulecm_pkg and uart_line_editor_command_matcher_core.
`timescale 1ns / 1ps
`default_nettype none

module ulecm_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input ulecm_pkg::rsp_item_type rsp_item
);
   import ulecm_pkg::*;

   // A result word that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result word changed or dropped while stalled");

   // The core works on one request word at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on two consecutive cycles");

   a_no_stray_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.match_found |-> rsp_item.command_number == 3'd0)
      else $error("command number without a match");

   // A dropped byte ends its request and echoes nothing.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status |-> rsp_item.last && !rsp_item.echo_valid)
      else $error("full status with echo or not last");

   a_line_end_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.line_end |-> rsp_item.echo_valid &&
         (rsp_item.echo_byte == CH_CR || rsp_item.echo_byte == CH_LF))
      else $error("line end mark without CR or LF echo");

endmodule

bind uart_line_editor_command_matcher_core ulecm_chk u_chk (.*);

`default_nettype wire
